/* hdl/mss_pkg.sv */
`default_nettype none

package mss_pkg;

  localparam int unsigned ValueW    = 16;
  localparam int unsigned SumFieldW = 25;
  localparam int unsigned IdxFieldW = 10;

  localparam logic [SumFieldW-1:0] SumFieldMax = {SumFieldW{1'b1}};

  typedef struct packed {
    logic                 overflow;
    logic [IdxFieldW-1:0] last_index;
    logic [IdxFieldW-1:0] first_index;
    logic [SumFieldW-1:0] best_sum;
    logic                 found;
  } result_t;

endpackage

`default_nettype wire

/* hdl/max_subarray_shortest.sv */
// Channel   Dir  Signals                           Content
// s_axis    in   tvalid tready tdata[15:0] tlast   one element, tlast on the final one
// m_axis    out  tvalid tready tdata[47:0] tuser   one result for each array
//
// A new request is accepted in every cycle unless a stalled result holds the input stage.
// An element passes the input register, then one add and compare updates the scan state.
// An array's result is loaded into the output register when its final element leaves the input register.
// Reset clears the scan state and both valid flags.
// A stalled result holds the input stage only when an array's final element waits behind it.
`default_nettype none

module max_subarray_shortest import mss_pkg::*; #(
  parameter int unsigned MAX_LEN    = 1024,
  parameter int unsigned VALUE_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // value[15:0]
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // best_sum[24:0], first_index[34:25],
                                             // last_index[44:35], zero fill[47:45]
  output logic [1:0]       m_axis_tuser_o    // found[0], overflow[1]
);

  logic              in_vld;
  logic [ValueW-1:0] in_value;
  logic              in_last;
  logic              adv;
  result_t           scan_res;
  result_t           out_res;

  mss_in_reg u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .value_i (s_axis_tdata_i),
    .last_i  (s_axis_tlast_i),
    .adv_i   (adv),
    .valid_o (in_vld),
    .value_o (in_value),
    .last_o  (in_last)
  );

  assign adv = in_vld && (!in_last || !m_axis_tvalid_o || m_axis_tready_i);

  mss_scan #(
    .MAX_LEN    (MAX_LEN),
    .VALUE_BITS (VALUE_BITS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .value_i  (in_value),
    .last_i   (in_last),
    .result_o (scan_res)
  );

  mss_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (adv && in_last),
    .result_i (scan_res),
    .ready_i  (m_axis_tready_i),
    .valid_o  (m_axis_tvalid_o),
    .result_o (out_res)
  );

  assign m_axis_tdata_o = {3'b000, out_res.last_index, out_res.first_index, out_res.best_sum};
  assign m_axis_tuser_o = {out_res.overflow, out_res.found};

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !out_res.found |-> (m_axis_tdata_o == '0))
    else $error("Empty result carries a nonzero sum or index.");

endmodule

`default_nettype wire

/* hdl/mss_in_reg.sv */
`default_nettype none

module mss_in_reg import mss_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [ValueW-1:0] value_i,
  input  wire logic              last_i,
  input  wire logic              adv_i,
  output logic                   valid_o,
  output logic [ValueW-1:0]      value_o,
  output logic                   last_o
);

  logic              vld_q, vld_d;
  logic [ValueW-1:0] value_q;
  logic              last_q;
  logic              load;

  assign ready_o = !vld_q || adv_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (adv_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      value_q <= value_i;
      last_q  <= last_i;
    end
  end

  assign valid_o = vld_q;
  assign value_o = value_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

/* hdl/mss_scan.sv */
`default_nettype none

module mss_scan import mss_pkg::*; #(
  parameter int unsigned MAX_LEN    = 1024,
  parameter int unsigned VALUE_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic [ValueW-1:0] value_i,
  input  wire logic              last_i,
  output result_t                result_o
);

  localparam int unsigned IdxW    = $clog2(MAX_LEN);
  localparam int unsigned PosW    = $clog2(MAX_LEN + 1);
  localparam int unsigned SumW    = VALUE_BITS + $clog2(MAX_LEN) + 1;
  localparam int unsigned RawW    = (VALUE_BITS > ValueW) ? VALUE_BITS : ValueW;
  localparam int unsigned ExtW    = (SumW > SumFieldW + 1) ? SumW : SumFieldW + 1;
  localparam int unsigned IdxExtW = (IdxW > IdxFieldW) ? IdxW : IdxFieldW;

  logic signed [SumW-1:0] run_sum_q, run_sum_d;
  logic [IdxW-1:0]        start_q, start_d;
  logic [PosW-1:0]        pos_q, pos_d;
  logic signed [SumW-1:0] best_q, best_d;
  logic [IdxW-1:0]        bfirst_q, bfirst_d;
  logic [IdxW-1:0]        blast_q, blast_d;
  logic                   ovf_q, ovf_d;

  logic [RawW-1:0]           raw_ext;
  logic signed [VALUE_BITS-1:0] raw;
  logic signed [SumW-1:0]    v;
  logic                      restart;
  logic [IdxW-1:0]           pos_idx;
  logic [IdxW-1:0]           cur_len;
  logic [IdxW-1:0]           best_len;
  logic [ExtW-1:0]           best_ext;
  logic [IdxExtW-1:0]        first_ext;
  logic [IdxExtW-1:0]        last_ext;

  assign raw_ext = RawW'(value_i);
  assign raw     = raw_ext[VALUE_BITS-1:0];
  assign v       = SumW'(raw);
  assign pos_idx = pos_q[IdxW-1:0];

  always_comb begin
    run_sum_d = run_sum_q;
    start_d   = start_q;
    pos_d     = pos_q;
    best_d    = best_q;
    bfirst_d  = bfirst_q;
    blast_d   = blast_q;
    ovf_d     = ovf_q;
    restart   = (pos_q == '0) || (run_sum_q <= 0);
    cur_len   = '0;
    best_len  = blast_q - bfirst_q;
    if (pos_q >= PosW'(MAX_LEN)) begin
      ovf_d = 1'b1;
    end else begin
      if (restart) begin
        run_sum_d = v;
        start_d   = pos_idx;
      end else begin
        run_sum_d = run_sum_q + v;
      end
      cur_len = pos_idx - start_d;
      if (run_sum_d > best_q) begin
        best_d   = run_sum_d;
        bfirst_d = start_d;
        blast_d  = pos_idx;
      end else if ((run_sum_d == best_q) && (run_sum_d > 0) && (cur_len < best_len)) begin
        bfirst_d = start_d;
        blast_d  = pos_idx;
      end
      pos_d = pos_q + 1'b1;
    end
  end

  assign best_ext  = ExtW'(best_d);
  assign first_ext = IdxExtW'(bfirst_d);
  assign last_ext  = IdxExtW'(blast_d);

  always_comb begin
    result_o = '0;
    result_o.overflow = ovf_d;
    if (best_d > 0) begin
      result_o.found       = 1'b1;
      result_o.best_sum    = (best_ext > ExtW'(SumFieldMax)) ? SumFieldMax
                                                            : best_ext[SumFieldW-1:0];
      result_o.first_index = first_ext[IdxFieldW-1:0];
      result_o.last_index  = last_ext[IdxFieldW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_sum_q <= '0;
      start_q   <= '0;
      pos_q     <= '0;
      best_q    <= '0;
      bfirst_q  <= '0;
      blast_q   <= '0;
      ovf_q     <= 1'b0;
    end else if (adv_i) begin
      if (last_i) begin
        run_sum_q <= '0;
        start_q   <= '0;
        pos_q     <= '0;
        best_q    <= '0;
        bfirst_q  <= '0;
        blast_q   <= '0;
        ovf_q     <= 1'b0;
      end else begin
        run_sum_q <= run_sum_d;
        start_q   <= start_d;
        pos_q     <= pos_d;
        best_q    <= best_d;
        bfirst_q  <= bfirst_d;
        blast_q   <= blast_d;
        ovf_q     <= ovf_d;
      end
    end
  end

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(MAX_LEN))
    else $error("Position counter passed the array limit.");

  a_best_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_q >= 0)
    else $error("Best sum went negative.");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && last_i |=> (pos_q == '0) && (best_q == 0) && !ovf_q)
    else $error("Scan state did not clear after the final element.");

endmodule

`default_nettype wire

/* hdl/mss_out_reg.sv */
`default_nettype none

module mss_out_reg import mss_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t result_i,
  input  wire logic    ready_i,
  output logic         valid_o,
  output result_t      result_o
);

  logic    vld_q, vld_d;
  result_t res_q;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign valid_o  = vld_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

/* tb/sv/mss_checker.sv */
`timescale 1ns / 100ps

module mss_checker import mss_pkg::*; #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [15:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [47:0] m_axis_tdata_i,
  input  logic [1:0]  m_axis_tuser_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic signed [25:0] run_total;
  logic signed [25:0] peak_total;
  logic [10:0]        elem_pos;
  logic [9:0]         run_begin;
  logic [9:0]         peak_first;
  logic [9:0]         peak_last;
  logic               too_long;
  result_t            results_due[$];
  int unsigned        fails;

  initial begin
    run_total  = '0;
    peak_total = '0;
    elem_pos   = '0;
    run_begin  = '0;
    peak_first = '0;
    peak_last  = '0;
    too_long   = 1'b0;
    fails      = 0;
  end

  // Kadane step on one element; on the final element the array's result is queued.
  function automatic void scan_element(input logic [15:0] raw, input logic fin);
    logic signed [25:0] v;
    result_t            r;
    v = $signed(raw);
    if (elem_pos >= MAX_LEN) begin
      too_long = 1'b1;
    end else begin
      if (elem_pos == 0 || run_total <= 0) begin
        run_total = v;
        run_begin = elem_pos[9:0];
      end else begin
        run_total = run_total + v;
      end
      if (run_total > peak_total) begin
        peak_total = run_total;
        peak_first = run_begin;
        peak_last  = elem_pos[9:0];
      end else if (run_total == peak_total && run_total > 0 &&
                   (elem_pos - 11'(run_begin)) < 11'(peak_last - peak_first)) begin
        peak_first = run_begin;
        peak_last  = elem_pos[9:0];
      end
      elem_pos = elem_pos + 11'd1;
    end
    if (fin) begin
      r = '0;
      if (peak_total > 0) begin
        r.found       = 1'b1;
        r.best_sum    = (peak_total > $signed({1'b0, SumFieldMax})) ? SumFieldMax
                                                                     : peak_total[24:0];
        r.first_index = peak_first;
        r.last_index  = peak_last;
      end
      r.overflow = too_long;
      results_due.push_back(r);
      run_total  = '0;
      peak_total = '0;
      elem_pos   = '0;
      run_begin  = '0;
      peak_first = '0;
      peak_last  = '0;
      too_long   = 1'b0;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.found       = m_axis_tuser_i[0];
        got.overflow    = m_axis_tuser_i[1];
        got.best_sum    = m_axis_tdata_i[24:0];
        got.first_index = m_axis_tdata_i[34:25];
        got.last_index  = m_axis_tdata_i[44:35];
        if (results_due.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("unexpected result: found=%0d sum=%0d first=%0d last=%0d ovf=%0d",
                     got.found, got.best_sum, got.first_index, got.last_index,
                     got.overflow);
          end
        end else begin
          want = results_due.pop_front();
          if (got.found !== want.found || got.best_sum !== want.best_sum ||
              got.first_index !== want.first_index ||
              got.last_index !== want.last_index || got.overflow !== want.overflow) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: expected found=%0d sum=%0d first=%0d last=%0d ovf=%0d",
                       want.found, want.best_sum, want.first_index, want.last_index,
                       want.overflow);
              $display("          actual   found=%0d sum=%0d first=%0d last=%0d ovf=%0d",
                       got.found, got.best_sum, got.first_index, got.last_index,
                       got.overflow);
            end
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        scan_element(s_axis_tdata_i, s_axis_tlast_i);
      end
      pending_o    <= results_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CycleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_arm = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  max_subarray_shortest i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  mss_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .fail_count_o    (mismatch_count),
    .pending_o       (results_pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // The long hold lets the block fill up while requests keep coming.
  always @(posedge clk_i) begin
    if (hold_arm && !hold_done) begin
      hold_left = 300;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [15:0] random_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      return 16'(int'($urandom_range(16)) - 8);
    end else if (pick < 80) begin
      return 16'($urandom);
    end
    case ($urandom_range(3))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  task automatic send_item(input logic [15:0] val, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
  endtask

  task automatic send_random_arrays(input int unsigned count, input int unsigned max_len);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(max_len, 13) : $urandom_range(12, 1);
      if (max_len < 13) begin
        len = $urandom_range(max_len, 1);
      end
      for (int unsigned i = 0; i < len; i++) begin
        send_item(random_value(), i == len - 1);
      end
      sent += len;
    end
  endtask

  task automatic set_traffic(input int unsigned idle, input int unsigned stall);
    idle_pct = idle;
    stall_pct <= stall;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(16'h7fff, 1'b1);
    send_item(16'h8000, 1'b1);
    send_item(16'h0000, 1'b0);
    send_item(16'h0000, 1'b1);
    send_item(16'd3, 1'b0);
    send_item(-16'sd3, 1'b0);
    send_item(16'd3, 1'b1);
    send_item(16'd1, 1'b0);
    send_item(16'd2, 1'b0);
    send_item(-16'sd3, 1'b0);
    send_item(16'd3, 1'b1);
    send_item(-16'sd5, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(-16'sd1, 1'b0);
    send_item(16'h8000, 1'b1);
    send_item(-16'sd1, 1'b0);
    send_item(16'd5, 1'b0);
    send_item(-16'sd2, 1'b0);
    send_item(16'd2, 1'b0);
    send_item(-16'sd7, 1'b0);
    send_item(16'd4, 1'b0);
    send_item(16'd1, 1'b0);
    send_item(16'h7fff, 1'b1);
    send_item(16'd9, 1'b1);
    wait_drained();

    send_random_arrays(140, 48);
    wait_drained();

    set_traffic(74, 0);
    send_random_arrays(130, 48);
    wait_drained();

    set_traffic(0, 74);
    send_random_arrays(130, 48);
    wait_drained();

    set_traffic(19, 19);
    send_random_arrays(120, 48);
    wait_drained();

    set_traffic(0, 0);
    hold_arm <= 1'b1;
    send_random_arrays(40, 2);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

/* max_subarray_shortest.f */
hdl/mss_pkg.sv
hdl/mss_in_reg.sv
hdl/mss_scan.sv
hdl/mss_out_reg.sv
hdl/max_subarray_shortest.sv
tb/sv/mss_checker.sv
tb/sv/tb.sv
